// ----- sv/hfve_pkg.sv -----
// Shared types and constants for the header field value extractor.
package hfve_pkg;

  localparam int NAME_SLOTS = 16;
  localparam int IDX_W      = 5;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_12_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_VALUE_BYTE = 2'd0;
  localparam logic [1:0] KIND_FOUND      = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [4:0] {
    PH_SEEK  = 5'b00001,
    PH_MATCH = 5'b00010,
    PH_SKIP  = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  // name character at the current match position
  typedef struct packed {
    logic       done;
    logic [7:0] chr;
  } name_tap_t;

endpackage

// ----- sv/hfve_name_cfg.sv -----
// Header name registers and the character lookup at the match position.
module hfve_name_cfg #(
  parameter int MAX_NAME_CHARS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hfve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata,
  input  logic [hfve_pkg::IDX_W-1:0]       match_idx,
  output hfve_pkg::name_tap_t              tap
);

  localparam logic [5:0] MAX_LEN = 6'(MAX_NAME_CHARS);

  logic [31:0] words_r [4];
  logic [4:0]  len_r;
  logic [5:0]  len_eff;
  logic        in_range;
  logic [7:0]  chr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) words_r[i] <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < hfve_pkg::CFG_NAME_LEN) begin
        words_r[cfg_index[1:0]] <= cfg_wdata;
      end else if (cfg_index == hfve_pkg::CFG_NAME_LEN) begin
        len_r <= cfg_wdata[4:0];
      end
    end
  end

  always_comb begin
    in_range = !match_idx[4];
    chr      = in_range ? words_r[match_idx[3:2]][{match_idx[1:0], 3'b000} +: 8] : 8'h00;
    len_eff  = ({1'b0, len_r} > MAX_LEN) ? MAX_LEN : {1'b0, len_r};
    tap.chr  = chr;
    // name ends at its length, past the last slot, or at its first zero character
    tap.done = ({1'b0, match_idx} >= len_eff) || !in_range || (chr == hfve_pkg::CH_NUL);
  end

endmodule

// ----- sv/hfve_scan.sv -----
// Line scanner, name compare, value streaming and the result register.
module hfve_scan #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_valid,
  input  logic [7:0]                  byte_data,
  output logic                        byte_take,
  input  hfve_pkg::name_tap_t         tap,
  output logic [hfve_pkg::IDX_W-1:0]  match_idx,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_vbyte,
  output logic [7:0]                  out_spaces,
  output logic [OFFSET_BITS-1:0]      out_offset
);

  hfve_pkg::phase_t             phase_r, phase_nxt;
  logic [hfve_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]                   pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0]       pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]       start_r, start_nxt;

  logic                         emit;
  logic [1:0]                   kind;
  logic [7:0]                   vb;
  logic [7:0]                   sp;
  logic [OFFSET_BITS-1:0]       off;
  logic                         out_room;
  logic                         fire;

  logic                         out_valid_r;
  logic [1:0]                   kind_r;
  logic [7:0]                   vb_r;
  logic [7:0]                   sp_r;
  logic [OFFSET_BITS-1:0]       off_r;

  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  assign match_idx = idx_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    start_nxt = start_r;
    pos_nxt   = pos_r + OFFSET_BITS'(1);
    emit      = 1'b0;
    kind      = hfve_pkg::KIND_VALUE_BYTE;
    vb        = 8'h00;
    sp        = 8'h00;
    off       = '0;
    if (byte_data == hfve_pkg::CH_NUL) begin
      case (phase_r)
        hfve_pkg::PH_SKIP: begin
          emit = 1'b1;
          kind = hfve_pkg::KIND_FOUND;
          off  = pos_r;
        end
        hfve_pkg::PH_VALUE: begin
          emit = 1'b1;
          kind = hfve_pkg::KIND_FOUND;
          off  = start_r;
        end
        hfve_pkg::PH_SEEK, hfve_pkg::PH_MATCH: begin
          emit = 1'b1;
          kind = hfve_pkg::KIND_NOT_FOUND;
        end
        default: ;
      endcase
      // block end: back to the reset state
      phase_nxt = hfve_pkg::PH_SEEK;
      idx_nxt   = '0;
      pend_nxt  = '0;
      pos_nxt   = '0;
      start_nxt = '0;
    end else begin
      case (phase_r)
        hfve_pkg::PH_MATCH: begin
          if (tap.done) begin
            if (byte_data == hfve_pkg::CH_COLON) begin
              phase_nxt = hfve_pkg::PH_SKIP;
            end else if (byte_data == hfve_pkg::CH_LF) begin
              phase_nxt = hfve_pkg::PH_MATCH;
              idx_nxt   = '0;
            end else begin
              phase_nxt = hfve_pkg::PH_SEEK;
            end
          end else if (up_ascii(byte_data) == up_ascii(tap.chr)) begin
            idx_nxt = idx_r + hfve_pkg::IDX_W'(1);
          end else if (byte_data == hfve_pkg::CH_LF) begin
            phase_nxt = hfve_pkg::PH_MATCH;
            idx_nxt   = '0;
          end else begin
            phase_nxt = hfve_pkg::PH_SEEK;
          end
        end
        hfve_pkg::PH_SKIP: begin
          if (byte_data != hfve_pkg::CH_SPACE) begin
            start_nxt = pos_r;
            pend_nxt  = '0;
            emit      = 1'b1;
            if (byte_data < hfve_pkg::CH_SPACE) begin
              kind      = hfve_pkg::KIND_FOUND;
              off       = pos_r;
              phase_nxt = hfve_pkg::PH_DONE;
            end else begin
              vb        = byte_data;
              phase_nxt = hfve_pkg::PH_VALUE;
            end
          end
        end
        hfve_pkg::PH_VALUE: begin
          if (byte_data == hfve_pkg::CH_SPACE) begin
            if (pend_r != 8'hFF) pend_nxt = pend_r + 8'd1;
          end else if (byte_data < hfve_pkg::CH_SPACE) begin
            emit      = 1'b1;
            kind      = hfve_pkg::KIND_FOUND;
            off       = start_r;
            pend_nxt  = '0;
            phase_nxt = hfve_pkg::PH_DONE;
          end else begin
            emit     = 1'b1;
            vb       = byte_data;
            sp       = pend_r;
            pend_nxt = '0;
          end
        end
        hfve_pkg::PH_SEEK: begin
          if (byte_data == hfve_pkg::CH_LF) begin
            phase_nxt = hfve_pkg::PH_MATCH;
            idx_nxt   = '0;
          end
        end
        default: phase_nxt = hfve_pkg::PH_DONE;
      endcase
    end
  end

  // bytes with no result move on even while the result register is stalled
  assign out_room  = !out_valid_r || out_ready;
  assign fire      = byte_valid && (!emit || out_room);
  assign byte_take = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hfve_pkg::PH_SEEK;
      idx_r       <= '0;
      pend_r      <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        pend_r  <= pend_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r <= kind;
      vb_r   <= vb;
      sp_r   <= sp;
      off_r  <= off;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_vbyte  = vb_r;
  assign out_spaces = sp_r;
  assign out_offset = off_r;

  a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && byte_data == hfve_pkg::CH_NUL) |=>
      (phase_r == hfve_pkg::PH_SEEK && pos_r == '0 && pend_r == '0))
    else $error("block end did not clear the search state");

  a_pending_only_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != hfve_pkg::PH_VALUE) |-> (pend_r == '0))
    else $error("held-back spaces outside the value");

  a_value_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == hfve_pkg::KIND_VALUE_BYTE) |-> (off_r == '0))
    else $error("value byte result carries an offset");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != hfve_pkg::KIND_VALUE_BYTE) |-> (vb_r == '0 && sp_r == '0))
    else $error("end result carries a value byte or space count");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(kind_r) && $stable(off_r)))
    else $error("stalled result register changed");

endmodule

// ----- sv/header_field_value_extractor.sv -----
// Top level of the header field value extractor.
// Takes one header byte per cycle and sustains one byte per cycle in both
// directions while a byte that gives a result finds room in the result
// register; a byte passes through the input register and, if it gives a
// result, lands in the result register. Bytes that give no result keep
// flowing while a result waits to be taken. Load the name characters and
// name_length while the block is idle. Results: kind 0 is a value byte with
// the count of interior spaces held back before it, kind 1 ends a found
// value and gives the value's offset in the block, kind 2 reports a block
// that ended without a match. A zero byte ends the block and restarts the
// search; the first line of a block is never a candidate.
module header_field_value_extractor #(
  parameter int MAX_NAME_CHARS = 16,
  parameter int OFFSET_BITS    = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [7:0]                                in_tdata,   // header_byte
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // value_byte [7:0], spaces_before [15:8], value_offset above, zero padded
  output logic [((16+OFFSET_BITS+7)/8)*8-1:0]       out_tdata,
  output logic [1:0]                                out_tuser,  // result_kind
  input  logic                                      cfg_we,
  input  logic [hfve_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [31:0]                               cfg_wdata
);

  localparam int OUT_W = ((16 + OFFSET_BITS + 7) / 8) * 8;

  logic                         in_valid_r;
  logic [7:0]                   in_byte_r;
  logic                         take;
  logic [hfve_pkg::IDX_W-1:0]   match_idx;
  hfve_pkg::name_tap_t          tap;
  logic [7:0]                   vbyte;
  logic [7:0]                   spaces;
  logic [OFFSET_BITS-1:0]       offset;

  assign in_tready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  hfve_name_cfg #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_name_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .match_idx (match_idx),
    .tap       (tap)
  );

  hfve_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_valid_r),
    .byte_data  (in_byte_r),
    .byte_take  (take),
    .tap        (tap),
    .match_idx  (match_idx),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_vbyte  (vbyte),
    .out_spaces (spaces),
    .out_offset (offset)
  );

  assign out_tdata = OUT_W'({offset, spaces, vbyte});

endmodule

// ----- dv/tb_header_field_value_extractor.sv -----
// Self-checking testbench for header_field_value_extractor: directed and random header blocks.
module tb_header_field_value_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vbyte;
    logic [7:0]  spaces;
    logic [15:0] offset;
  } field_result_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = 8'h00;   // header_byte
  logic                           out_tvalid;
  logic                           out_tready = 1'b1;
  logic [31:0]                    out_tdata;            // value_byte, spaces_before, value_offset
  logic [1:0]                     out_tuser;            // result_kind
  logic                           cfg_we     = 1'b0;
  logic [hfve_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]                    cfg_wdata  = '0;

  header_field_value_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of configuration and search state
  logic [7:0]       name_chr [hfve_pkg::NAME_SLOTS] = '{default: 8'h00};
  logic [4:0]       name_len    = '0;
  hfve_pkg::phase_t scan_phase  = hfve_pkg::PH_SEEK;
  logic [4:0]       match_idx   = '0;
  logic [7:0]       held_spaces = '0;
  logic [15:0]      byte_pos    = '0;
  logic [15:0]      val_start   = '0;

  field_result_t field_results_q[$];

  // stimulus-side copy of the loaded name
  logic [7:0] gen_name [hfve_pkg::NAME_SLOTS] = '{default: 8'h00};
  logic [4:0] gen_len = '0;

  int err_count  = 0;
  int sent_count = 0;
  bit idle_on    = 1'b1;
  int stall_left = 0;

  function automatic logic [7:0] ascii_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void apply_cfg_write(input logic [hfve_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
    if (idx <= hfve_pkg::CFG_NAME_12_15) begin
      for (int k = 0; k < 4; k++) name_chr[idx*4 + k] = val[8*k +: 8];
    end else if (idx == hfve_pkg::CFG_NAME_LEN) begin
      name_len = val[4:0];
    end
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] vb,
                                      input logic [7:0] sp, input logic [15:0] off);
    field_result_t r;
    r.kind   = kind;
    r.vbyte  = vb;
    r.spaces = sp;
    r.offset = off;
    field_results_q.push_back(r);
  endfunction

  function automatic void restart_line_scan(input logic [7:0] b);
    if (b == hfve_pkg::CH_LF) begin
      scan_phase = hfve_pkg::PH_MATCH;
      match_idx  = '0;
    end else begin
      scan_phase = hfve_pkg::PH_SEEK;
    end
  endfunction

  function automatic void predict_header_byte(input logic [7:0] b);
    logic [15:0] pos;
    int          lim;
    bit          at_name_end;
    pos      = byte_pos;
    byte_pos = byte_pos + 16'd1;
    if (b == hfve_pkg::CH_NUL) begin
      case (scan_phase)
        hfve_pkg::PH_SKIP:
          push_result(hfve_pkg::KIND_FOUND, 8'd0, 8'd0, pos);
        hfve_pkg::PH_VALUE:
          push_result(hfve_pkg::KIND_FOUND, 8'd0, 8'd0, val_start);
        hfve_pkg::PH_SEEK, hfve_pkg::PH_MATCH:
          push_result(hfve_pkg::KIND_NOT_FOUND, 8'd0, 8'd0, 16'd0);
        default: ;
      endcase
      scan_phase  = hfve_pkg::PH_SEEK;
      match_idx   = '0;
      held_spaces = '0;
      byte_pos    = '0;
      val_start   = '0;
      return;
    end
    case (scan_phase)
      hfve_pkg::PH_SEEK: restart_line_scan(b);
      hfve_pkg::PH_MATCH: begin
        lim = (name_len > hfve_pkg::NAME_SLOTS) ? hfve_pkg::NAME_SLOTS : name_len;
        at_name_end = (match_idx >= lim) || (name_chr[match_idx[3:0]] == hfve_pkg::CH_NUL);
        if (at_name_end) begin
          if (b == hfve_pkg::CH_COLON) scan_phase = hfve_pkg::PH_SKIP;
          else restart_line_scan(b);
        end else if (ascii_upper(b) == ascii_upper(name_chr[match_idx[3:0]])) begin
          match_idx = match_idx + 5'd1;
        end else begin
          restart_line_scan(b);
        end
      end
      hfve_pkg::PH_SKIP: begin
        if (b != hfve_pkg::CH_SPACE) begin
          val_start   = pos;
          held_spaces = '0;
          if (b < hfve_pkg::CH_SPACE) begin
            push_result(hfve_pkg::KIND_FOUND, 8'd0, 8'd0, val_start);
            scan_phase = hfve_pkg::PH_DONE;
          end else begin
            push_result(hfve_pkg::KIND_VALUE_BYTE, b, 8'd0, 16'd0);
            scan_phase = hfve_pkg::PH_VALUE;
          end
        end
      end
      hfve_pkg::PH_VALUE: begin
        if (b == hfve_pkg::CH_SPACE) begin
          if (held_spaces != 8'hFF) held_spaces = held_spaces + 8'd1;
        end else if (b < hfve_pkg::CH_SPACE) begin
          push_result(hfve_pkg::KIND_FOUND, 8'd0, 8'd0, val_start);
          held_spaces = '0;
          scan_phase  = hfve_pkg::PH_DONE;
        end else begin
          push_result(hfve_pkg::KIND_VALUE_BYTE, b, held_spaces, 16'd0);
          held_spaces = '0;
        end
      end
      default: scan_phase = hfve_pkg::PH_DONE;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    field_result_t exp_r;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (field_results_q.size() == 0) begin
        $error("unexpected result transaction: tuser=%0d tdata=%h", out_tuser, out_tdata);
        err_count++;
      end else begin
        exp_r = field_results_q.pop_front();
        if (out_tuser !== exp_r.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_r.kind, out_tuser);
          err_count++;
        end
        if (out_tdata[7:0] !== exp_r.vbyte) begin
          $error("value_byte: expected %h, got %h", exp_r.vbyte, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== exp_r.spaces) begin
          $error("spaces_before: expected %0d, got %0d", exp_r.spaces, out_tdata[15:8]);
          err_count++;
        end
        if (out_tdata[31:16] !== exp_r.offset) begin
          $error("value_offset: expected %0d, got %0d", exp_r.offset, out_tdata[31:16]);
          err_count++;
        end
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left = $urandom_range(7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    predict_header_byte(b);
    sent_count++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // block must be idle: nothing pending and the pipeline flushed
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (field_results_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [hfve_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_cfg_write(idx, val);
    @(negedge clk);
  endtask

  task automatic load_name(input logic [4:0] len);
    logic [31:0] w;
    gen_len = len;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) w[8*k +: 8] = gen_name[r*4 + k];
      write_reg(hfve_pkg::CFG_NAME_0_3 + hfve_pkg::CFG_IDX_W'(r), w);
    end
    // upper bits of the length word are don't-care
    write_reg(hfve_pkg::CFG_NAME_LEN, {27'($urandom()), len});
    write_reg(hfve_pkg::CFG_IDX_W'($urandom_range((1 << hfve_pkg::CFG_IDX_W) - 1,
                                                  hfve_pkg::CFG_NAME_LEN + 1)),
              $urandom());
    cfg_we <= 1'b0;
  endtask

  task automatic use_name(input string nm, input logic [4:0] len);
    for (int i = 0; i < hfve_pkg::NAME_SLOTS; i++)
      gen_name[i] = (i < nm.len()) ? nm[i] : hfve_pkg::CH_NUL;
    load_name(len);
  endtask

  function automatic int name_eff();
    int n;
    n = (gen_len > hfve_pkg::NAME_SLOTS) ? hfve_pkg::NAME_SLOTS : gen_len;
    for (int i = 0; i < n; i++) if (gen_name[i] == hfve_pkg::CH_NUL) return i;
    return n;
  endfunction

  task automatic pick_random_name();
    logic [4:0] len;
    for (int i = 0; i < hfve_pkg::NAME_SLOTS; i++) begin
      case ($urandom_range(9))
        0: gen_name[i] = 8'($urandom_range(255));
        1: gen_name[i] = "-";
        default: gen_name[i] = $urandom_range(1) ? 8'($urandom_range("Z", "A"))
                                                 : 8'($urandom_range("z", "a"));
      endcase
    end
    case ($urandom_range(7))
      0: len = '0;
      1: len = 5'($urandom_range(31, hfve_pkg::NAME_SLOTS + 1));
      2: len = 5'(hfve_pkg::NAME_SLOTS);
      default: len = 5'($urandom_range(6, 1));
    endcase
    load_name(len);
  endtask

  // name line with random letter case; a partial one ends in a random byte after part or all of the name
  task automatic send_field_line(input bit full);
    int         n;
    int         cut;
    logic [7:0] c;
    n   = name_eff();
    cut = full ? n : $urandom_range(n);
    for (int i = 0; i < cut; i++) begin
      c = gen_name[i];
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
        c = c ^ 8'h20;
      send_byte(c);
    end
    if (!full) begin
      send_byte(8'($urandom_range(255, 1)));
      return;
    end
    send_byte(hfve_pkg::CH_COLON);
    repeat ($urandom_range(3)) send_byte(hfve_pkg::CH_SPACE);
    repeat ($urandom_range(12)) begin
      if ($urandom_range(3) == 0) begin
        repeat (($urandom_range(49) == 0) ? $urandom_range(300, 256) : $urandom_range(4, 1))
          send_byte(hfve_pkg::CH_SPACE);
      end else begin
        send_byte(8'($urandom_range(255, 33)));
      end
    end
    case ($urandom_range(3))
      0: begin
        send_byte(8'h0D);
        send_byte(hfve_pkg::CH_LF);
      end
      1: send_byte(hfve_pkg::CH_LF);
      2: send_byte(8'($urandom_range(31, 1)));
      default: ;
    endcase
  endtask

  task automatic send_random_block();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20, 1)) send_byte(8'($urandom_range(255)));
      send_byte(hfve_pkg::CH_NUL);
    end else begin
      // the first line may carry the name too; it must never match
      if ($urandom_range(1)) send_field_line(1'b1);
      else repeat ($urandom_range(6)) send_byte(8'($urandom_range(126, 33)));
      send_byte(hfve_pkg::CH_LF);
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(3))
          0, 1: send_field_line(1'b1);
          2: send_field_line(1'b0);
          default: repeat ($urandom_range(10, 1)) send_byte(8'($urandom_range(255, 1)));
        endcase
        if ($urandom_range(3) != 0) send_byte(hfve_pkg::CH_LF);
      end
      send_byte(hfve_pkg::CH_NUL);
    end
  endtask

  // empty name after reset: any line but a block's first that starts with a colon matches
  task automatic test_reset_defaults();
    send_str("A:x\n: v1 \015");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
  endtask

  task automatic test_search_rules();
    use_name("hO", 5'd2);
    send_str("Ho:x\nHO: a  b \377~\001z");  // first line skipped, end after done
    send_byte(hfve_pkg::CH_NUL);
    send_str("\nH\nHo:");                    // newline restarts match, end in skip
    send_byte(hfve_pkg::CH_NUL);
    send_str("\nHox:\nHo:\t");               // non-colon after name, empty value
    send_byte(hfve_pkg::CH_NUL);
    send_str("\nHo: v");                     // end while streaming
    send_byte(hfve_pkg::CH_NUL);
    send_str("x");
    send_byte(hfve_pkg::CH_NUL);
    send_str("\nH");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
  endtask

  task automatic test_name_forms();
    use_name("ABCDEFGHIJKLMNOP", 5'd31);     // length clamps to the slot count
    send_str("\nabcdefghijklmnop:Q\015");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
    use_name("aB", 5'd5);                    // name stops at its first zero char
    send_str("\nAB:1\n");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
    use_name("ABCDEFGHIJKLMNOP", 5'd16);
    send_str("\nABCDEFGHIJKLMNOPQ:z\n");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
  endtask

  task automatic test_space_saturation();
    use_name("Ho", 5'd2);
    send_str("\nHo:a");
    repeat (257) send_byte(hfve_pkg::CH_SPACE);
    send_byte("b");
    repeat (3) send_byte(hfve_pkg::CH_SPACE);
    send_str("c\015");
    send_byte(hfve_pkg::CH_NUL);
    drain_results();
  endtask

  task automatic test_random_headers(input int n_items, input bit with_idle);
    int start;
    start = sent_count;
    idle_on = with_idle;
    while (sent_count - start < n_items) begin
      if ($urandom_range(4) == 0) begin
        drain_results();
        pick_random_name();
      end
      if (with_idle) idle_on = ($urandom_range(3) != 0);
      send_random_block();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_search_rules();
    test_name_forms();
    test_space_saturation();
    test_random_headers(240, 1'b1);
    test_random_headers(30, 1'b0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
